### sv/dism_pkg.sv
`timescale 1ns / 1ps

package dism_pkg;

	// Request sector field and how many of its bits take part in the lookup
	localparam int SECTOR_NUMBER_BITS = 16;
	localparam int SecWidth = 16;

	// Register and result widths
	localparam int CfgWidth   = 32;
	localparam int SizeWidth  = 16;
	localparam int OffWidth   = 26;
	localparam int XferWidth  = 10;
	localparam int TotalWidth = 29;
	localparam int AddrWidth  = 2;
	// Wide enough to hold any header byte count without wrap
	localparam int ByteWidth  = 36;

	localparam int HdrBytes   = 16;
	localparam int BootBytes  = 3 * 128;

	// Well-known data sizes used when the header geometry does not fit the file
	localparam logic [CfgWidth-1:0] SizeEnhanced = CfgWidth'(128 * 1040);
	localparam logic [CfgWidth-1:0] SizeSingle   = CfgWidth'(128 * 720);
	localparam logic [CfgWidth-1:0] SizeDouble   = CfgWidth'(256 * 720 - 3 * 128);
	localparam logic [CfgWidth-1:0] SizeDblFull  = CfgWidth'(256 * 720);

	typedef enum logic [AddrWidth-1:0] {
		REG_PARAGRAPHS,
		REG_SECTOR_SIZE,
		REG_FILE_SIZE,
		REG_PROTECT
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_RANGE,
		ST_PROT,
		ST_BAD
	} status_t;

	// Sector pitch in the file
	typedef enum logic [1:0] {
		PITCH_128,
		PITCH_256,
		PITCH_512
	} pitch_t;

	// Disk geometry derived from the header registers
	typedef struct packed {
		logic                  bad;
		logic                  protect;
		logic                  size512;
		logic [XferWidth-1:0]  xfer;
		pitch_t                pitch;
		logic                  broken;
		logic [TotalWidth-1:0] total;
	} geo_t;

endpackage

### sv/dism_cfg.sv
`timescale 1ns / 1ps

module dism_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [dism_pkg::AddrWidth-1:0] addr,
	input  logic [dism_pkg::CfgWidth-1:0]  wdata,
	output dism_pkg::geo_t                geo_q
);
	import dism_pkg::*;

	logic [CfgWidth-1:0]  paragraphs_q;
	logic [SizeWidth-1:0] sector_size_q;
	logic [CfgWidth-1:0]  file_size_q;
	logic                 protect_q;

	logic                  ssz128, ssz256, ssz512;
	logic [CfgWidth-1:0]   data;
	logic [CfgWidth-1:0]   tail_units;
	logic [ByteWidth-1:0]  data_w;
	logic [ByteWidth-1:0]  ns_bytes;
	logic [ByteWidth-1:0]  expected;
	logic [TotalWidth-1:0] cnt;
	pitch_t                pitch;
	logic                  broken;
	geo_t                  geo_d;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paragraphs_q  <= '0;
			sector_size_q <= SizeWidth'(128);
			file_size_q   <= '0;
			protect_q     <= 1'b0;
		end else if (we) begin
			case (reg_idx_t'(addr))
				REG_PARAGRAPHS:  paragraphs_q  <= wdata;
				REG_SECTOR_SIZE: sector_size_q <= wdata[SizeWidth-1:0];
				REG_FILE_SIZE:   file_size_q   <= wdata;
				REG_PROTECT:     protect_q     <= wdata[0];
				default:         protect_q     <= protect_q;
			endcase
		end
	end

	assign ssz128     = (sector_size_q == SizeWidth'(128));
	assign ssz256     = (sector_size_q == SizeWidth'(256));
	assign ssz512     = (sector_size_q == SizeWidth'(512));
	assign data       = file_size_q - CfgWidth'(HdrBytes);
	assign data_w     = ByteWidth'(data);
	assign tail_units = paragraphs_q - CfgWidth'(3 * 8);
	assign ns_bytes   = {paragraphs_q[CfgWidth-1:4], 8'b0};

	// Geometry from the header, then the fallbacks keyed on the data size
	always_comb begin
		if (ssz256 && paragraphs_q > CfgWidth'(3 * 8)) begin
			cnt      = TotalWidth'(tail_units[CfgWidth-1:4]) + TotalWidth'(3);
			expected = {tail_units[CfgWidth-1:4], 8'b0} + ByteWidth'(BootBytes);
			pitch    = PITCH_256;
		end else if (ssz512) begin
			cnt      = TotalWidth'(paragraphs_q[CfgWidth-1:5]);
			expected = {paragraphs_q[CfgWidth-1:5], 9'b0};
			pitch    = PITCH_512;
		end else begin
			cnt      = paragraphs_q[CfgWidth-1:3];
			expected = {paragraphs_q[CfgWidth-1:3], 7'b0};
			pitch    = PITCH_128;
		end
		broken = 1'b0;
		if (expected != data_w) begin
			if (data_w == ns_bytes) begin
				cnt    = TotalWidth'(paragraphs_q[CfgWidth-1:4]);
				pitch  = PITCH_256;
				broken = 1'b1;
			end else if (data == SizeEnhanced) begin
				cnt   = TotalWidth'(1040);
				pitch = PITCH_128;
			end else if (data == SizeSingle) begin
				cnt   = TotalWidth'(720);
				pitch = PITCH_128;
			end else if (data == SizeDouble) begin
				cnt   = TotalWidth'(720);
				pitch = PITCH_256;
			end else if (data == SizeDblFull) begin
				cnt    = TotalWidth'(720);
				pitch  = PITCH_256;
				broken = 1'b1;
			end
		end

		geo_d.bad     = (file_size_q < CfgWidth'(HdrBytes)) || (data[6:0] != 7'd0) ||
			(paragraphs_q[2:0] != 3'd0) || !(ssz128 || ssz256 || ssz512);
		geo_d.protect = protect_q;
		geo_d.size512 = ssz512;
		geo_d.xfer    = sector_size_q[XferWidth-1:0];
		geo_d.pitch   = pitch;
		geo_d.broken  = broken;
		geo_d.total   = cnt;
	end

	// Geometry is held in flops, loaded from the header registers after a register write
	always_ff @(posedge clk) begin
		geo_q <= geo_d;
	end

endmodule

### sv/dism_map.sv
`timescale 1ns / 1ps

module dism_map (
	input  logic                           kind,
	input  logic [dism_pkg::SecWidth-1:0]  sector_number,
	input  dism_pkg::geo_t                 geo,
	output dism_pkg::status_t              status,
	output logic [dism_pkg::OffWidth-1:0]  byte_offset,
	output logic [dism_pkg::XferWidth-1:0] transfer_size,
	output logic [dism_pkg::TotalWidth-1:0] sector_total
);
	import dism_pkg::*;

	localparam int SecBits = (SECTOR_NUMBER_BITS < SecWidth) ? SECTOR_NUMBER_BITS : SecWidth;
	localparam logic [SecWidth-1:0] SecMask = SecWidth'((64'd1 << SecBits) - 64'd1);

	logic [SecWidth-1:0] sec, sec_m1, sec_m4;
	logic                first3, out_of_range;
	logic [OffWidth-1:0] off;

	// Sector scaled by the pitch
	function automatic logic [OffWidth-1:0] scale(input logic [SecWidth-1:0] v,
		input pitch_t p);
		logic [OffWidth-1:0] r;
		case (p)
			PITCH_128: r = OffWidth'({v, 7'b0});
			PITCH_256: r = OffWidth'({v, 8'b0});
			PITCH_512: r = OffWidth'({v, 9'b0});
			default:   r = '0;
		endcase
		return r;
	endfunction

	assign sec          = sector_number & SecMask;
	assign sec_m1       = sec - SecWidth'(1);
	assign sec_m4       = sec - SecWidth'(4);
	assign first3       = (sec <= SecWidth'(3));
	assign out_of_range = (sec == '0) || (TotalWidth'(sec) > geo.total);

	// Boot sectors are 128 bytes unless the layout is uniform
	always_comb begin
		if (geo.broken || geo.size512) begin
			off = scale(sec_m1, geo.pitch);
		end else if (first3) begin
			off = scale(sec_m1, PITCH_128);
		end else begin
			off = scale(sec_m4, geo.pitch) + OffWidth'(BootBytes);
		end
	end

	always_comb begin
		if (geo.bad) begin
			status        = ST_BAD;
			byte_offset   = '0;
			transfer_size = '0;
			sector_total  = '0;
		end else if (out_of_range) begin
			status        = ST_RANGE;
			byte_offset   = '0;
			transfer_size = '0;
			sector_total  = geo.total;
		end else begin
			status        = (kind && geo.protect) ? ST_PROT : ST_OK;
			byte_offset   = off + OffWidth'(HdrBytes);
			transfer_size = (!geo.size512 && first3) ? XferWidth'(128) : geo.xfer;
			sector_total  = geo.total;
		end
	end

endmodule

### sv/disk_image_sector_mapper_core.sv
`timescale 1ns / 1ps

// channel   direction  handshake             word
// cfg       in         cfg_we                cfg_addr, cfg_wdata
// in        in         in_valid / in_ready   kind, sector_number
// out       out        out_valid / out_ready status, byte_offset, transfer_size, sector_total
//
// One request per cycle while in_ready is high; a taken request is held in the
// input register, mapped into the result register and leaves from there.
// Register writes reach the geometry flops through the header registers; in_ready is low
// while cfg_we is high. Reset loads the header registers with their defaults.
// A stalled result holds in the output register; in_ready drops only while cfg_we is
// high or when both stages are full and out_ready is low.

module disk_image_sector_mapper_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dism_pkg::AddrWidth-1:0]  cfg_addr,
	input  logic [dism_pkg::CfgWidth-1:0]   cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [dism_pkg::SecWidth-1:0]   sector_number,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [dism_pkg::OffWidth-1:0]   byte_offset,
	output logic [dism_pkg::XferWidth-1:0]  transfer_size,
	output logic [dism_pkg::TotalWidth-1:0] sector_total
);
	import dism_pkg::*;

	geo_t                  geo_q;
	logic                  valid_s1, kind_s1;
	logic [SecWidth-1:0]   sector_s1;
	logic                  out_valid_q;
	logic                  advance, take;
	status_t               status_d;
	logic [OffWidth-1:0]   offset_d;
	logic [XferWidth-1:0]  xfer_d;
	logic [TotalWidth-1:0] total_d;
	logic [1:0]            status_q;
	logic [OffWidth-1:0]   offset_q;
	logic [XferWidth-1:0]  xfer_q;
	logic [TotalWidth-1:0] total_q;

	dism_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.addr  (cfg_addr),
		.wdata (cfg_wdata),
		.geo_q (geo_q)
	);

	dism_map u_map (
		.kind         (kind_s1),
		.sector_number(sector_s1),
		.geo          (geo_q),
		.status       (status_d),
		.byte_offset  (offset_d),
		.transfer_size(xfer_d),
		.sector_total (total_d)
	);

	// Handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !cfg_we && (!valid_s1 || !out_valid_q || out_ready);
	assign take     = in_valid && in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1   <= kind;
			sector_s1 <= sector_number;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			offset_q <= offset_d;
			xfer_q   <= xfer_d;
			total_q  <= total_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign byte_offset   = offset_q;
	assign transfer_size = xfer_q;
	assign sector_total  = total_q;

endmodule

### sv/dism_chk.sv
`timescale 1ns / 1ps

module dism_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [1:0]                      status,
	input logic [dism_pkg::OffWidth-1:0]   byte_offset,
	input logic [dism_pkg::XferWidth-1:0]  transfer_size,
	input logic [dism_pkg::TotalWidth-1:0] sector_total
);
	import dism_pkg::*;

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_offset) &&
		$stable(transfer_size) && $stable(sector_total))
		else $error("result word changed while stalled");

	// No request is taken in a register write cycle
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_ready)
		else $error("request taken during register write");

	// A bad image reports nothing but its status
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD |->
		byte_offset == '0 && transfer_size == '0 && sector_total == '0)
		else $error("bad image word carries data");

	// Out of range gives no transfer
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE |-> byte_offset == '0 && transfer_size == '0)
		else $error("out of range word carries a transfer");

	// A served sector moves a legal size past the header
	a_served: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK || status == ST_PROT) |->
		(transfer_size == XferWidth'(128) || transfer_size == XferWidth'(256) ||
		transfer_size == XferWidth'(512)) && byte_offset[3:0] == 4'd0 &&
		byte_offset != '0)
		else $error("served word has bad size or offset");

endmodule

bind disk_image_sector_mapper_core dism_chk u_dism_chk (.*);
